>>> rtl/pai_pkg.sv
// shared types and constants for the positional insert/delete list
// no dependencies
package pai_pkg;

   localparam int unsigned DEF_CAPACITY = 64;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned CNT_W        = 7;
   localparam int unsigned IDX_W        = 6;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_POS  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_ROTATE = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [CNT_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

>>> rtl/pai_cell.sv
// one storage cell of the list chain, trades its entry with its neighbors
// depends on pai_pkg
module pai_cell import pai_pkg::*; #(
   parameter int unsigned INDEX = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] prev_value,
   input  logic signed [DATA_W-1:0] next_value,
   input  logic signed [DATA_W-1:0] head_value,
   output logic signed [DATA_W-1:0] value
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
            value_in = value_ff;
         end
         OP_WRITE: begin
            if (MY_IDX == ctrl.pos) value_in = ctrl.value;
         end
         OP_INSERT: begin
            if (MY_IDX > ctrl.pos) value_in = prev_value;
            else if (MY_IDX == ctrl.pos) value_in = ctrl.value;
         end
         OP_DELETE: begin
            if (MY_IDX >= ctrl.pos) value_in = next_value;
         end
         OP_ROTATE: begin
            if (MY_IDX == ctrl.pos) value_in = head_value;
            else if (MY_IDX < ctrl.pos) value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/positional_array_insert_delete_core.sv
// top level of the positional insert/delete list: control and the cell chain
// depends on pai_pkg and pai_cell
//
//   channel   ports                                   handshake
//   request   req_command req_start_new req_position  start high, busy low
//             req_value
//   response  rsp_status rsp_element rsp_element_index rsp_valid, one cycle
//             rsp_new_count rsp_last
//
// load, insert and delete move every cell at once, so a new request is
// taken in the next cycle and its response follows in the cycle after
// acceptance. a dump holds busy while the chain rotates its entries through
// cell 0, one response per cycle. reset clears the count and control; cell
// contents are undefined until written. the response side has no
// back-pressure.
module positional_array_insert_delete_core import pai_pkg::*; #(
   parameter int unsigned CAPACITY = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic                     req_start_new,
   input  logic [CNT_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [IDX_W-1:0]         rsp_element_index,
   output logic [CNT_W-1:0]         rsp_new_count,
   output logic                     rsp_last
);

   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         dump_idx_ff, dump_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     accept;
   logic [CNT_W-1:0]         base_count;
   logic                     dump_final;
   cmd_type                  cmd;

   assign cmd        = cmd_type'(req_command);
   assign accept     = start && (state_ff == S_IDLE);
   assign base_count = (cmd == CMD_LOAD && req_start_new) ? '0 : count_ff;
   assign dump_final = (({1'b0, dump_idx_ff} + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_element_in = '0;
      rsp_index_in   = '0;
      rsp_count_in   = count_ff;
      rsp_last_in    = 1'b1;
      ctrl.op        = OP_HOLD;
      ctrl.pos       = req_position;
      ctrl.value     = req_value;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (cmd)
                  CMD_LOAD: begin
                     if (base_count >= CAP) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.op  = OP_WRITE;
                        ctrl.pos = base_count;
                        count_in = base_count + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (req_position > count_ff) begin
                        rsp_status_in = ST_BAD_POS;
                     end else if (count_ff >= CAP) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.op  = OP_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (req_position >= count_ff) begin
                        rsp_status_in = ST_BAD_POS;
                     end else begin
                        ctrl.op  = OP_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        dump_idx_in  = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         S_DUMP: begin
            ctrl.op        = OP_ROTATE;
            ctrl.pos       = count_ff - CNT_W'(1);
            rsp_valid_in   = 1'b1;
            rsp_element_in = cell_value[0];
            rsp_index_in   = dump_idx_ff;
            rsp_last_in    = dump_final;
            dump_idx_in    = dump_idx_ff + IDX_W'(1);
            if (dump_final) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_v, next_v;
      if (i == 0) begin : g_first
         assign prev_v = cell_value[0];
      end else begin : g_prev
         assign prev_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign next_v = cell_value[i];
      end else begin : g_next
         assign next_v = cell_value[i+1];
      end
      pai_cell #(.INDEX(i)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .prev_value (prev_v),
         .next_value (next_v),
         .head_value (cell_value[0]),
         .value      (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_idx_ff    <= dump_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy              = (state_ff == S_DUMP);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_new_count     = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> rtl/pai_checker.sv
// port-level checks for the positional insert/delete list, bound to the top
// depends on pai_pkg and positional_array_insert_delete_core
module pai_checker import pai_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [1:0]               rsp_status,
   input logic [IDX_W-1:0]         rsp_element_index,
   input logic [CNT_W-1:0]         rsp_new_count,
   input logic                     rsp_last
);

   // errors always end their request
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error response without last");

   // dump stream has no gaps
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside dump stream");

   // dump indices count up by one
   a_stream_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_element_index == $past(rsp_element_index) + IDX_W'(1))
      else $error("dump index did not advance");

   // a non-final entry lies below the count
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
         ({1'b0, rsp_element_index} + CNT_W'(1)) < rsp_new_count)
      else $error("dump index out of range");

   // an accepted request answers or goes busy next cycle
   a_accept_follow: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("request dropped");

endmodule

bind positional_array_insert_delete_core pai_checker u_pai_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_element_index (rsp_element_index),
   .rsp_new_count     (rsp_new_count),
   .rsp_last          (rsp_last)
);

>>> tb/pai_list_checker.sv
`timescale 1ns / 1ps
// response checker for the positional insert/delete list: keeps its own copy of
// the list, predicts every response of each accepted request and compares in order
// depends on pai_pkg
module pai_list_checker import pai_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_command,
   input  logic                     req_start_new,
   input  logic [CNT_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic [1:0]               rsp_status,
   input  logic signed [DATA_W-1:0] rsp_element,
   input  logic [IDX_W-1:0]         rsp_element_index,
   input  logic [CNT_W-1:0]         rsp_new_count,
   input  logic                     rsp_last,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int CAP = DEF_CAPACITY;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic [IDX_W-1:0]         index;
      logic [CNT_W-1:0]         count;
      logic                     last;
   } list_rsp_type;

   logic signed [DATA_W-1:0] shadow_list [CAP];
   int                       shadow_count = 0;
   list_rsp_type             due_rsp_q [$];
   list_rsp_type             head;
   list_rsp_type             item;
   status_type               req_status;
   bit                       dumped;
   int                       mismatches = 0;
   int                       i;

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         due_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (due_rsp_q.size() == 0) begin
               if (mismatches < 10)
                  $display({"unexpected response: status %0d element %0d index %0d ",
                            "count %0d last %0b"},
                           rsp_status, rsp_element, rsp_element_index, rsp_new_count,
                           rsp_last);
               mismatches++;
            end else begin
               head = due_rsp_q.pop_front();
               if (rsp_status !== head.status || rsp_element !== head.element ||
                   rsp_element_index !== head.index || rsp_new_count !== head.count ||
                   rsp_last !== head.last) begin
                  if (mismatches < 10)
                     $display({"response mismatch at %0t: expected status %0d element %0d ",
                               "index %0d count %0d last %0b, got status %0d element %0d ",
                               "index %0d count %0d last %0b"},
                              $realtime, head.status, head.element, head.index, head.count,
                              head.last, rsp_status, rsp_element, rsp_element_index,
                              rsp_new_count, rsp_last);
                  mismatches++;
               end
            end
         end

         if (start && !busy) begin
            req_status = ST_OK;
            dumped     = 1'b0;
            case (cmd_type'(req_command))
               CMD_LOAD: begin
                  if (req_start_new)
                     shadow_count = 0;
                  if (shadow_count >= CAP) begin
                     req_status = ST_FULL;
                  end else begin
                     shadow_list[shadow_count[IDX_W-1:0]] = req_value;
                     shadow_count++;
                  end
               end
               CMD_INSERT: begin
                  if (int'(req_position) > shadow_count) begin
                     req_status = ST_BAD_POS;
                  end else if (shadow_count >= CAP) begin
                     req_status = ST_FULL;
                  end else begin
                     for (i = shadow_count; i > int'(req_position); i--)
                        shadow_list[i[IDX_W-1:0]] = shadow_list[IDX_W'(i - 1)];
                     shadow_list[req_position[IDX_W-1:0]] = req_value;
                     shadow_count++;
                  end
               end
               CMD_DELETE: begin
                  if (int'(req_position) >= shadow_count) begin
                     req_status = ST_BAD_POS;
                  end else begin
                     for (i = int'(req_position); i + 1 < shadow_count; i++)
                        shadow_list[i[IDX_W-1:0]] = shadow_list[IDX_W'(i + 1)];
                     shadow_count--;
                  end
               end
               default: begin
                  if (shadow_count == 0) begin
                     req_status = ST_EMPTY;
                  end else begin
                     dumped = 1'b1;
                     for (i = 0; i < shadow_count; i++) begin
                        item.status  = ST_OK;
                        item.element = shadow_list[i[IDX_W-1:0]];
                        item.index   = i[IDX_W-1:0];
                        item.count   = shadow_count[CNT_W-1:0];
                        item.last    = (i + 1 == shadow_count);
                        due_rsp_q.push_back(item);
                     end
                  end
               end
            endcase
            if (!dumped) begin
               item.status  = req_status;
               item.element = '0;
               item.index   = '0;
               item.count   = shadow_count[CNT_W-1:0];
               item.last    = 1'b1;
               due_rsp_q.push_back(item);
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= due_rsp_q.size();
   end

endmodule

>>> tb/tb_positional_array_insert_delete_core.sv
`timescale 1ns / 1ps
// testbench top for positional_array_insert_delete_core: drives directed and random
// requests with random idle bursts and reports the verdict
// depends on pai_pkg, the core and pai_list_checker
module tb_positional_array_insert_delete_core;
   import pai_pkg::*;

   localparam int CAP = DEF_CAPACITY;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_command = '0;
   logic                     req_start_new = 1'b0;
   logic [CNT_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic [IDX_W-1:0]         rsp_element_index;
   logic [CNT_W-1:0]         rsp_new_count;
   logic                     rsp_last;
   int                       fail_count;
   int                       pending_count;

   int                       list_len = 0;
   int                       issued = 0;
   bit                       idling = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   positional_array_insert_delete_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_start_new     (req_start_new),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element       (rsp_element),
      .rsp_element_index (rsp_element_index),
      .rsp_new_count     (rsp_new_count),
      .rsp_last          (rsp_last)
   );

   pai_list_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_start_new     (req_start_new),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element       (rsp_element),
      .rsp_element_index (rsp_element_index),
      .rsp_new_count     (rsp_new_count),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_pos(input int hi);
      return CNT_W'($urandom_range(0, hi));
   endfunction

   function automatic logic pick_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic cmd_type pick_cmd();
      return cmd_type'(2'($urandom_range(0, 3)));
   endfunction

   task automatic pause(input int cycles);
      start         <= 1'b0;
      req_command   <= 2'($urandom_range(0, 3));
      req_start_new <= pick_bit();
      req_position  <= pick_pos(127);
      req_value     <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // holds the request until the core takes it
   task automatic issue(input cmd_type cmd, input logic sn, input logic [CNT_W-1:0] pos,
                        input logic signed [DATA_W-1:0] val);
      if (idling && $urandom_range(0, 3) == 0)
         pause($urandom_range(1, 11));
      start         <= 1'b1;
      req_command   <= cmd;
      req_start_new <= sn;
      req_position  <= pos;
      req_value     <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
      case (cmd)
         CMD_LOAD: begin
            if (sn)
               list_len = 0;
            if (list_len < CAP)
               list_len++;
         end
         CMD_INSERT: if (int'(pos) <= list_len && list_len < CAP) list_len++;
         CMD_DELETE: if (int'(pos) < list_len) list_len--;
         default: ;
      endcase
   endtask

   // load a new list up to a target size; if it is full, probe the full-list responses
   task automatic fill_list(input int target);
      issue(CMD_LOAD, 1'b1, pick_pos(127), pick_value());
      while (list_len < target)
         issue(CMD_LOAD, 1'b0, pick_pos(127), pick_value());
      if (list_len == CAP) begin
         issue(CMD_LOAD, 1'b0, pick_pos(127), pick_value());
         issue(CMD_INSERT, pick_bit(), pick_pos(CAP), pick_value());
         issue(CMD_INSERT, 1'b0, CNT_W'(CAP + 1), pick_value());
         issue(CMD_DUMP, 1'b0, '0, '0);
         issue(CMD_DELETE, 1'b0, CNT_W'(CAP - 1), pick_value());
      end
   endtask

   initial begin
      int r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, edges of the position range, extreme values
      issue(CMD_DUMP,   1'b0, 7'd0,   '0);
      issue(CMD_DELETE, 1'b0, 7'd0,   '0);
      issue(CMD_INSERT, 1'b0, 7'd1,   32'sd5);
      issue(CMD_LOAD,   1'b0, 7'd0,   32'sh7FFF_FFFF);
      issue(CMD_LOAD,   1'b1, 7'd127, 32'sh8000_0000);
      issue(CMD_INSERT, 1'b0, 7'd0,   32'sd0);
      issue(CMD_INSERT, 1'b0, 7'd2,   -32'sd1);
      issue(CMD_INSERT, 1'b0, 7'd127, 32'sd9);
      issue(CMD_INSERT, 1'b0, 7'd4,   32'sd9);
      issue(CMD_DELETE, 1'b0, 7'd3,   '0);
      issue(CMD_DELETE, 1'b1, 7'd127, '0);
      issue(CMD_DUMP,   1'b0, 7'd0,   '0);
      issue(CMD_DELETE, 1'b0, 7'd1,   '0);
      issue(CMD_DELETE, 1'b0, 7'd1,   '0);
      issue(CMD_DELETE, 1'b0, 7'd0,   '0);
      issue(CMD_DUMP,   1'b1, 7'd127, 32'sh7FFF_FFFF);
      issue(CMD_LOAD,   1'b1, 7'd0,   32'sh5555_5555);
      issue(CMD_LOAD,   1'b0, 7'd0,   32'shAAAA_AAAA);
      issue(CMD_INSERT, 1'b1, 7'd1,   -32'sd2);
      issue(CMD_DUMP,   1'b0, 7'd0,   '0);

      fill_list(CAP);

      while (issued < 470) begin
         if (issued > 390)
            idling = 1'b0;
         r = $urandom_range(0, 9);
         if (r == 0) begin
            fill_list(($urandom_range(0, 3) == 0) ? CAP : $urandom_range(1, 16));
         end else if (r == 1) begin
            repeat (4)
               issue(pick_cmd(), pick_bit(), pick_pos(127), pick_value());
         end else begin
            repeat (8) begin
               r = $urandom_range(0, 15);
               if (list_len > 24 && r < 10)
                  r = 12;
               if (r == 0)
                  issue(CMD_DUMP, pick_bit(), pick_pos(127), pick_value());
               else if (r < 5)
                  issue(CMD_LOAD, ($urandom_range(0, 15) == 0), pick_pos(127),
                        pick_value());
               else if ((r < 10 && list_len < CAP) || list_len == 0)
                  issue(CMD_INSERT, pick_bit(), pick_pos(list_len), pick_value());
               else
                  issue(CMD_DELETE, pick_bit(), pick_pos(list_len - 1), pick_value());
            end
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("positional_array_insert_delete_core test passed");
      else
         $display("positional_array_insert_delete_core test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("positional_array_insert_delete_core test failed");
      $finish;
   end

endmodule
